// File: hdl/cbt_pkg.sv
package cbt_pkg;

    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [11:0]        stroke_width;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic [7:0]         alpha;
        logic [15:0]        tex_coord;
        logic               path_end;
    } point_t;

    typedef struct packed {
        logic signed [15:0] out_x;
        logic signed [15:0] out_y;
        logic [11:0]        out_width;
        logic [7:0]         out_red;
        logic [7:0]         out_green;
        logic [7:0]         out_blue;
        logic [7:0]         out_alpha;
        logic [15:0]        out_tex;
        logic               run_last;
        logic               path_done;
    } result_t;

    // one control point: x, y (offset binary), width, r, g, b, a, tex
    typedef logic [7:0][15:0] slot_t;

    localparam int NUM_LANES = 8;
    localparam int LANE_X    = 0;
    localparam int LANE_Y    = 1;
    localparam int LANE_W    = 2;
    localparam int LANE_R    = 3;
    localparam int LANE_G    = 4;
    localparam int LANE_B    = 5;
    localparam int LANE_A    = 6;
    localparam int LANE_T    = 7;

    localparam logic [11:0] STEP_RESET = 12'd80;
    localparam int          ADDR_W     = 3;
    localparam logic        REG_STEP   = 1'b0;

    localparam logic [4:0] CNT_ROOT = 5'd16;
    localparam logic [4:0] CNT_DIV  = 5'd16;

    // blend step, counted down
    localparam logic [4:0] BL_Q0 = 5'd5;
    localparam logic [4:0] BL_Q1 = 5'd4;
    localparam logic [4:0] BL_Q2 = 5'd3;
    localparam logic [4:0] BL_R0 = 5'd2;
    localparam logic [4:0] BL_R1 = 5'd1;
    localparam logic [4:0] BL_F  = 5'd0;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ANCHOR,
        S_CHECK,
        S_FILL,
        S_DIFF,
        S_SQUARE,
        S_SQRT,
        S_LEN,
        S_DIVQ,
        S_SEGS,
        S_DIVT,
        S_TINIT,
        S_NEXT,
        S_BLEND,
        S_POINT,
        S_END
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_ANCHOR,
        OP_FILL,
        OP_DIFF,
        OP_SQUARE,
        OP_SQRT_STEP,
        OP_DIVQ_INIT,
        OP_DIV_STEP,
        OP_SEGS,
        OP_TINIT,
        OP_NEXT,
        OP_BLEND,
        OP_POINT,
        OP_END
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic started;
        logic seg_due;
        logic cnt_last;
        logic last_point;
        logic out_free;
    } stat_t;

endpackage

// File: hdl/cbt_ctrl.sv
module cbt_ctrl
    import cbt_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  point_valid,
    input  stat_t stat,
    output cmd_t  cmd,
    output logic  point_stall
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (point_valid)
                begin
                    state_next = stat.started ? S_CHECK : S_ANCHOR;
                end
            end
            S_ANCHOR:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_CHECK:  state_next = stat.seg_due ? S_FILL : S_IDLE;
            S_FILL:   state_next = S_DIFF;
            S_DIFF:   state_next = S_SQUARE;
            S_SQUARE: state_next = S_SQRT;
            S_SQRT:
            begin
                if (stat.cnt_last)
                begin
                    state_next = S_LEN;
                end
            end
            S_LEN:    state_next = S_DIVQ;
            S_DIVQ:
            begin
                if (stat.cnt_last)
                begin
                    state_next = S_SEGS;
                end
            end
            S_SEGS:   state_next = S_DIVT;
            S_DIVT:
            begin
                if (stat.cnt_last)
                begin
                    state_next = S_TINIT;
                end
            end
            S_TINIT:  state_next = S_NEXT;
            S_NEXT:   state_next = stat.last_point ? S_END : S_BLEND;
            S_BLEND:
            begin
                if (stat.cnt_last)
                begin
                    state_next = S_POINT;
                end
            end
            S_POINT:
            begin
                if (stat.out_free)
                begin
                    state_next = S_NEXT;
                end
            end
            S_END:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.op      = OP_NONE;
        point_stall = (state_reg != S_IDLE);
        case (state_reg)
            S_IDLE:   cmd.op = point_valid ? OP_CAPTURE : OP_NONE;
            S_ANCHOR: cmd.op = stat.out_free ? OP_ANCHOR : OP_NONE;
            S_FILL:   cmd.op = OP_FILL;
            S_DIFF:   cmd.op = OP_DIFF;
            S_SQUARE: cmd.op = OP_SQUARE;
            S_SQRT:   cmd.op = OP_SQRT_STEP;
            S_LEN:    cmd.op = OP_DIVQ_INIT;
            S_DIVQ:   cmd.op = OP_DIV_STEP;
            S_SEGS:   cmd.op = OP_SEGS;
            S_DIVT:   cmd.op = OP_DIV_STEP;
            S_TINIT:  cmd.op = OP_TINIT;
            S_NEXT:   cmd.op = stat.last_point ? OP_NONE : OP_NEXT;
            S_BLEND:  cmd.op = OP_BLEND;
            S_POINT:  cmd.op = stat.out_free ? OP_POINT : OP_NONE;
            S_END:    cmd.op = stat.out_free ? OP_END : OP_NONE;
            default:  cmd.op = OP_NONE;
        endcase
    end

endmodule

// File: hdl/cbt_dp.sv
module cbt_dp
    import cbt_pkg::*;
#(
    parameter int MAX_SEGMENTS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [11:0] step_pixels,
    input  point_t      point,
    input  cmd_t        cmd,
    input  logic        result_stall,
    output stat_t       stat,
    output result_t     result,
    output logic        result_valid
);

    localparam int SEG_W = $clog2(MAX_SEGMENTS + 1);

    slot_t              slot_reg [4];
    slot_t              slot_next [4];
    logic [1:0]         pend_reg, pend_next;
    logic               started_reg, started_next;
    logic               done_reg, done_next;
    logic [15:0]        dx_reg, dx_next;
    logic [15:0]        dy_reg, dy_next;
    logic [33:0]        rad_reg, rad_next;
    logic [33:0]        root_reg, root_next;
    logic [16:0]        dvd_reg, dvd_next;
    logic [11:0]        rem_reg, rem_next;
    logic [11:0]        dsr_reg, dsr_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic [SEG_W-1:0]   segs_reg, segs_next;
    logic [16:0]        tq_reg, tq_next;
    logic [SEG_W-1:0]   tr_reg, tr_next;
    logic [SEG_W-1:0]   acc_reg, acc_next;
    logic [16:0]        t_reg, t_next;
    logic [SEG_W-1:0]   j_reg, j_next;
    logic [31:0]        bl_reg [6][NUM_LANES];
    logic [31:0]        bl_next [6][NUM_LANES];
    result_t            result_reg, result_next;
    logic               result_valid_reg, result_valid_next;

    logic [33:0]        root_bit;
    logic [33:0]        root_trial;
    logic [12:0]        div_sh;
    logic [SEG_W:0]     acc_sum;
    logic [SEG_W-1:0]   segs_calc;
    logic [2:0]         bl_dst;
    logic [31:0]        lane_a [NUM_LANES];
    logic [31:0]        lane_b [NUM_LANES];
    logic signed [32:0] lane_d [NUM_LANES];
    logic signed [50:0] lane_p [NUM_LANES];
    logic [34:0]        lane_s [NUM_LANES];
    logic [15:0]        lane_v [NUM_LANES];
    slot_t              point_slot;
    slot_t              blend_slot;

    function automatic result_t mk_result(slot_t s, logic run, logic done);
        result_t r;
        r.out_x     = s[LANE_X] ^ 16'h8000;
        r.out_y     = s[LANE_Y] ^ 16'h8000;
        r.out_width = s[LANE_W][11:0];
        r.out_red   = s[LANE_R][7:0];
        r.out_green = s[LANE_G][7:0];
        r.out_blue  = s[LANE_B][7:0];
        r.out_alpha = s[LANE_A][7:0];
        r.out_tex   = s[LANE_T];
        r.run_last  = run;
        r.path_done = done;
        return r;
    endfunction

    always_comb
    begin
        point_slot[LANE_X] = point.pos_x ^ 16'h8000;
        point_slot[LANE_Y] = point.pos_y ^ 16'h8000;
        point_slot[LANE_W] = {4'b0, point.stroke_width};
        point_slot[LANE_R] = {8'b0, point.red};
        point_slot[LANE_G] = {8'b0, point.green};
        point_slot[LANE_B] = {8'b0, point.blue};
        point_slot[LANE_A] = {8'b0, point.alpha};
        point_slot[LANE_T] = point.tex_coord;
    end

    // shared lerp lanes: a + round((b - a) * t)
    always_comb
    begin
        bl_dst = 3'(BL_Q0 - cnt_reg);
        for (int k = 0; k < NUM_LANES; k++)
        begin
            case (cnt_reg)
                BL_Q0:
                begin
                    lane_a[k] = {slot_reg[0][k], 16'h0};
                    lane_b[k] = {slot_reg[1][k], 16'h0};
                end
                BL_Q1:
                begin
                    lane_a[k] = {slot_reg[1][k], 16'h0};
                    lane_b[k] = {slot_reg[2][k], 16'h0};
                end
                BL_Q2:
                begin
                    lane_a[k] = {slot_reg[2][k], 16'h0};
                    lane_b[k] = {slot_reg[3][k], 16'h0};
                end
                BL_R0:
                begin
                    lane_a[k] = bl_reg[0][k];
                    lane_b[k] = bl_reg[1][k];
                end
                BL_R1:
                begin
                    lane_a[k] = bl_reg[1][k];
                    lane_b[k] = bl_reg[2][k];
                end
                default:
                begin
                    lane_a[k] = bl_reg[3][k];
                    lane_b[k] = bl_reg[4][k];
                end
            endcase
            lane_d[k] = $signed({1'b0, lane_b[k]}) - $signed({1'b0, lane_a[k]});
            lane_p[k] = lane_d[k] * $signed({1'b0, t_reg}) + 51'sd32768;
            lane_s[k] = {3'b0, lane_a[k]} + 35'(lane_p[k][50:16]);
            lane_v[k] = 16'((bl_reg[5][k] + 32'd32768) >> 16);
            blend_slot[k] = lane_v[k];
        end
    end

    always_comb
    begin
        root_bit   = 34'd1 << {cnt_reg, 1'b0};
        root_trial = root_reg + root_bit;
        div_sh     = {rem_reg, dvd_reg[16]};
        acc_sum    = {1'b0, acc_reg} + {1'b0, tr_reg};
        if (step_pixels == 12'd0 || dvd_reg >= 17'(MAX_SEGMENTS - 1))
        begin
            segs_calc = SEG_W'(MAX_SEGMENTS);
        end
        else
        begin
            segs_calc = dvd_reg[SEG_W-1:0] + SEG_W'(1);
        end
    end

    always_comb
    begin
        for (int s = 0; s < 4; s++)
        begin
            slot_next[s] = slot_reg[s];
        end
        for (int b = 0; b < 6; b++)
        begin
            for (int k = 0; k < NUM_LANES; k++)
            begin
                bl_next[b][k] = bl_reg[b][k];
            end
        end
        pend_next         = pend_reg;
        started_next      = started_reg;
        done_next         = done_reg;
        dx_next           = dx_reg;
        dy_next           = dy_reg;
        rad_next          = rad_reg;
        root_next         = root_reg;
        dvd_next          = dvd_reg;
        rem_next          = rem_reg;
        dsr_next          = dsr_reg;
        cnt_next          = cnt_reg;
        segs_next         = segs_reg;
        tq_next           = tq_reg;
        tr_next           = tr_reg;
        acc_next          = acc_reg;
        t_next            = t_reg;
        j_next            = j_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && result_stall;

        case (cmd.op)
            OP_CAPTURE:
            begin
                done_next = point.path_end;
                if (started_reg)
                begin
                    slot_next[pend_reg + 2'd1] = point_slot;
                    pend_next = pend_reg + 2'd1;
                end
                else
                begin
                    slot_next[0] = point_slot;
                end
            end
            OP_ANCHOR:
            begin
                result_next       = mk_result(slot_reg[0], 1'b1, done_reg);
                result_valid_next = 1'b1;
                pend_next         = 2'd0;
                started_next      = !done_reg;
            end
            OP_FILL:
            begin
                if (pend_reg == 2'd1)
                begin
                    slot_next[2] = slot_reg[1];
                    slot_next[3] = slot_reg[1];
                end
                else if (pend_reg == 2'd2)
                begin
                    slot_next[3] = slot_reg[2];
                end
            end
            OP_DIFF:
            begin
                dx_next = (slot_reg[3][LANE_X] >= slot_reg[0][LANE_X])
                        ? slot_reg[3][LANE_X] - slot_reg[0][LANE_X]
                        : slot_reg[0][LANE_X] - slot_reg[3][LANE_X];
                dy_next = (slot_reg[3][LANE_Y] >= slot_reg[0][LANE_Y])
                        ? slot_reg[3][LANE_Y] - slot_reg[0][LANE_Y]
                        : slot_reg[0][LANE_Y] - slot_reg[3][LANE_Y];
            end
            OP_SQUARE:
            begin
                rad_next  = 34'({16'd0, dx_reg} * {16'd0, dx_reg})
                          + 34'({16'd0, dy_reg} * {16'd0, dy_reg});
                root_next = 34'd0;
                cnt_next  = CNT_ROOT;
            end
            OP_SQRT_STEP:
            begin
                if (rad_reg >= root_trial)
                begin
                    rad_next  = rad_reg - root_trial;
                    root_next = (root_reg >> 1) + root_bit;
                end
                else
                begin
                    root_next = root_reg >> 1;
                end
                cnt_next = cnt_reg - 5'd1;
            end
            OP_DIVQ_INIT:
            begin
                dvd_next = root_reg[16:0];
                rem_next = 12'd0;
                dsr_next = step_pixels;
                cnt_next = CNT_DIV;
            end
            OP_DIV_STEP:
            begin
                if (div_sh >= {1'b0, dsr_reg})
                begin
                    rem_next = 12'(div_sh - {1'b0, dsr_reg});
                    dvd_next = {dvd_reg[15:0], 1'b1};
                end
                else
                begin
                    rem_next = div_sh[11:0];
                    dvd_next = {dvd_reg[15:0], 1'b0};
                end
                cnt_next = cnt_reg - 5'd1;
            end
            OP_SEGS:
            begin
                segs_next = segs_calc;
                dvd_next  = 17'h10000;
                rem_next  = 12'd0;
                dsr_next  = 12'(segs_calc);
                cnt_next  = CNT_DIV;
            end
            OP_TINIT:
            begin
                tq_next  = dvd_reg;
                tr_next  = rem_reg[SEG_W-1:0];
                acc_next = '0;
                t_next   = 17'd0;
                j_next   = '0;
            end
            OP_NEXT:
            begin
                j_next = j_reg + SEG_W'(1);
                if (acc_sum >= {1'b0, segs_reg})
                begin
                    acc_next = SEG_W'(acc_sum - {1'b0, segs_reg});
                    t_next   = t_reg + tq_reg + 17'd1;
                end
                else
                begin
                    acc_next = acc_sum[SEG_W-1:0];
                    t_next   = t_reg + tq_reg;
                end
                cnt_next = BL_Q0;
            end
            OP_BLEND:
            begin
                for (int k = 0; k < NUM_LANES; k++)
                begin
                    bl_next[bl_dst][k] = lane_s[k][31:0];
                end
                cnt_next = cnt_reg - 5'd1;
            end
            OP_POINT:
            begin
                result_next       = mk_result(blend_slot, 1'b0, 1'b0);
                result_valid_next = 1'b1;
            end
            OP_END:
            begin
                result_next       = mk_result(slot_reg[3], 1'b1, done_reg);
                result_valid_next = 1'b1;
                slot_next[0]      = slot_reg[3];
                pend_next         = 2'd0;
                if (done_reg)
                begin
                    started_next = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < 4; s++)
            begin
                slot_reg[s] <= '0;
            end
            pend_reg         <= 2'd0;
            started_reg      <= 1'b0;
            done_reg         <= 1'b0;
            cnt_reg          <= 5'd0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            for (int s = 0; s < 4; s++)
            begin
                slot_reg[s] <= slot_next[s];
            end
            pend_reg         <= pend_next;
            started_reg      <= started_next;
            done_reg         <= done_next;
            cnt_reg          <= cnt_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg     <= dx_next;
        dy_reg     <= dy_next;
        rad_reg    <= rad_next;
        root_reg   <= root_next;
        dvd_reg    <= dvd_next;
        rem_reg    <= rem_next;
        dsr_reg    <= dsr_next;
        segs_reg   <= segs_next;
        tq_reg     <= tq_next;
        tr_reg     <= tr_next;
        acc_reg    <= acc_next;
        t_reg      <= t_next;
        j_reg      <= j_next;
        result_reg <= result_next;
        for (int b = 0; b < 6; b++)
        begin
            for (int k = 0; k < NUM_LANES; k++)
            begin
                bl_reg[b][k] <= bl_next[b][k];
            end
        end
    end

    assign stat.started    = started_reg;
    assign stat.seg_due    = (pend_reg == 2'd3) || done_reg;
    assign stat.cnt_last   = (cnt_reg == 5'd0);
    assign stat.last_point = ({1'b0, j_reg} + (SEG_W+1)'(1)) >= {1'b0, segs_reg};
    assign stat.out_free   = !result_valid_reg || !result_stall;

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

endmodule

// File: hdl/cubic_bezier_tessellator.sv
// Cubic Bezier path tessellator. The first point of a path comes straight back
// as one result; every third point after it (or an earlier point marked
// path_end) closes a cubic segment and yields segments-1 blended interior points
// followed by the end point, with run_last on the last one and path_done where
// the path ends. A closing point first runs the one-bit-per-cycle root unit
// for the chord length (17 steps), then the divider, shared by the step count
// (17 steps) and the parameter increment (17 steps), before its first
// interior point; each interior point comes from the six-step blend through
// one lerp unit per attribute, and the end point follows. Output back-pressure
// can hold every result. step_pixels at byte address 0 may be written only
// while the block is idle.
module cubic_bezier_tessellator
    import cbt_pkg::*;
#(
    parameter int MAX_SEGMENTS = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              point_valid,
    output logic              point_stall,
    input  point_t            point,
    output logic              result_valid,
    input  logic              result_stall,
    output result_t           result
);

    logic [11:0] step_reg, step_next;
    cmd_t        cmd;
    stat_t       stat;

    always_comb
    begin
        step_next = step_reg;
        if (psel && penable && pwrite && paddr[ADDR_W-1:2] == REG_STEP)
        begin
            step_next = pwdata[11:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_RESET;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[ADDR_W-1:2] == REG_STEP) ? {20'b0, step_reg} : 32'd0;

    cbt_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .point_valid (point_valid),
        .stat        (stat),
        .cmd         (cmd),
        .point_stall (point_stall)
    );

    cbt_dp #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .step_pixels  (step_reg),
        .point        (point),
        .cmd          (cmd),
        .result_stall (result_stall),
        .stat         (stat),
        .result       (result),
        .result_valid (result_valid)
    );

endmodule

// File: hdl/cbt_chk.sv
module cbt_chk
    import cbt_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    point_valid,
    input logic    point_stall,
    input logic    result_valid,
    input logic    result_stall,
    input result_t result
);

    // hold a stalled result transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        point_valid && !point_stall |=> point_stall)
    else $error("input taken while busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.path_done |-> result.run_last)
    else $error("path end without run end");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.run_last |-> point_stall)
    else $error("input open inside a run");

endmodule

bind cubic_bezier_tessellator cbt_chk u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .point_valid  (point_valid),
    .point_stall  (point_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

// File: bench/cubic_bezier_tessellator_tb.sv
module cubic_bezier_tessellator_tb;
    import cbt_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_SEG   = 32;
    localparam int CYCLE_CAP = 1500000;

    class path_scoreboard;
        logic [15:0] ctl_x[4];
        logic [15:0] ctl_y[4];
        logic [15:0] ctl_attr[4][6];
        int unsigned waiting;
        bit          open_path;
        logic [11:0] step_q84;
        result_t     due_points[$];
        int unsigned errors;
        int unsigned checked;

        function void clear_path();
            for (int s = 0; s < 4; s++)
            begin
                ctl_x[s] = '0;
                ctl_y[s] = '0;
                for (int k = 0; k < 6; k++)
                    ctl_attr[s][k] = '0;
            end
            waiting = 0;
            open_path = 0;
            step_q84 = STEP_RESET;
        endfunction

        function void queue_point(result_t r);
            due_points = {due_points, r};
        endfunction

        function void store(int s, point_t p);
            ctl_x[s] = p.pos_x ^ 16'h8000;
            ctl_y[s] = p.pos_y ^ 16'h8000;
            ctl_attr[s][0] = p.stroke_width;
            ctl_attr[s][1] = p.red;
            ctl_attr[s][2] = p.green;
            ctl_attr[s][3] = p.blue;
            ctl_attr[s][4] = p.alpha;
            ctl_attr[s][5] = p.tex_coord;
        endfunction

        function void dup(int d, int s);
            ctl_x[d] = ctl_x[s];
            ctl_y[d] = ctl_y[s];
            ctl_attr[d] = ctl_attr[s];
        endfunction

        function logic [63:0] lane(int s, int k);
            if (k == LANE_X)
                return ctl_x[s];
            if (k == LANE_Y)
                return ctl_y[s];
            return ctl_attr[s][k - 2];
        endfunction

        function logic [63:0] mix(logic [63:0] a, logic [63:0] b, logic [63:0] t);
            return (a * (64'd65536 - t) + b * t + 64'd32768) >> 16;
        endfunction

        function result_t pack_point(logic [63:0] v[8]);
            result_t r;
            r.out_x = v[LANE_X][15:0] ^ 16'h8000;
            r.out_y = v[LANE_Y][15:0] ^ 16'h8000;
            r.out_width = v[LANE_W][11:0];
            r.out_red = v[LANE_R][7:0];
            r.out_green = v[LANE_G][7:0];
            r.out_blue = v[LANE_B][7:0];
            r.out_alpha = v[LANE_A][7:0];
            r.out_tex = v[LANE_T][15:0];
            r.run_last = 0;
            r.path_done = 0;
            return r;
        endfunction

        function void tessellate(bit done);
            logic [63:0] dx, dy, sq, root, bitv, segs, t, q0, q1, q2, r0, r1;
            logic [63:0] v[8];
            result_t r;
            dx = ctl_x[3] >= ctl_x[0] ? ctl_x[3] - ctl_x[0] : ctl_x[0] - ctl_x[3];
            dy = ctl_y[3] >= ctl_y[0] ? ctl_y[3] - ctl_y[0] : ctl_y[0] - ctl_y[3];
            sq = dx * dx + dy * dy;
            root = 0;
            bitv = 64'd1 << 62;
            while (bitv > sq)
                bitv >>= 2;
            while (bitv != 0)
            begin
                if (sq >= root + bitv)
                begin
                    sq -= root + bitv;
                    root = (root >> 1) + bitv;
                end
                else
                    root >>= 1;
                bitv >>= 2;
            end
            if (step_q84 == 0 || root / step_q84 >= MAX_SEG - 1)
                segs = MAX_SEG;
            else
                segs = root / step_q84 + 1;
            for (logic [63:0] j = 1; j < segs; j++)
            begin
                t = (j << 16) / segs;
                for (int k = 0; k < 8; k++)
                begin
                    q0 = mix(lane(0, k) << 16, lane(1, k) << 16, t);
                    q1 = mix(lane(1, k) << 16, lane(2, k) << 16, t);
                    q2 = mix(lane(2, k) << 16, lane(3, k) << 16, t);
                    r0 = mix(q0, q1, t);
                    r1 = mix(q1, q2, t);
                    v[k] = (mix(r0, r1, t) + 64'd32768) >> 16;
                end
                queue_point(pack_point(v));
            end
            for (int k = 0; k < 8; k++)
                v[k] = lane(3, k);
            r = pack_point(v);
            r.run_last = 1;
            r.path_done = done;
            queue_point(r);
            dup(0, 3);
            waiting = 0;
            if (done)
                open_path = 0;
        endfunction

        function void note_point(point_t p);
            logic [63:0] v[8];
            result_t r;
            if (!open_path)
            begin
                store(0, p);
                for (int k = 0; k < 8; k++)
                    v[k] = lane(0, k);
                r = pack_point(v);
                r.run_last = 1;
                r.path_done = p.path_end;
                queue_point(r);
                waiting = 0;
                open_path = !p.path_end;
                return;
            end
            store(1 + waiting, p);
            waiting++;
            if (waiting >= 3)
                tessellate(p.path_end);
            else if (p.path_end)
            begin
                if (waiting == 1)
                    dup(2, 1);
                dup(3, 2);
                tessellate(1);
            end
        endfunction

        function void check_point(result_t got);
            result_t want;
            checked++;
            if (due_points.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result %h", $time, got);
                return;
            end
            want = due_points.pop_front();
            if (got.out_x !== want.out_x || got.out_y !== want.out_y
                || got.out_width !== want.out_width || got.out_red !== want.out_red
                || got.out_green !== want.out_green || got.out_blue !== want.out_blue
                || got.out_alpha !== want.out_alpha || got.out_tex !== want.out_tex
                || got.run_last !== want.run_last || got.path_done !== want.path_done)
            begin
                errors++;
                $display("%0t: mismatch expected %h actual %h", $time, want, got);
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    logic              point_valid;
    logic              point_stall;
    point_t            point;
    logic              result_valid;
    logic              result_stall;
    result_t           result;

    path_scoreboard sb;
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  hold_off;
    int  cycles;
    int  sent;

    cubic_bezier_tessellator #(.MAX_SEGMENTS(MAX_SEG)) DUT (.*);

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    initial
    begin
        sb = new();
        sb.errors = 0;
        sb.checked = 0;
        sb.clear_path();
        rst_n = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        point_valid = 0;
        point = '0;
        result_stall = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off = 0;
        cycles = 0;
        sent = 0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("timeout at %0t", $time);
            $display("** cubic_bezier_tessellator: FAILED **");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n)
            result_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);

    always @(posedge clk)
        if (rst_n && result_valid && !result_stall)
            sb.check_point(result);

    task automatic write_step(logic [11:0] v);
        @(posedge clk);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= ADDR_W'(REG_STEP) << 2;
        pwdata <= {20'd0, v};
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        sb.step_q84 = v;
    endtask

    task automatic send_point(point_t p);
        while ($urandom_range(99) < send_idle_pct)
        begin
            point_valid <= 0;
            @(posedge clk);
        end
        point_valid <= 1;
        point <= p;
        do
            @(posedge clk);
        while (point_stall);
        sb.note_point(p);
        sent++;
        point_valid <= 0;
        @(posedge clk);
    endtask

    task automatic drain();
        while (sb.due_points.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    function automatic point_t rand_point(bit done, bit near);
        point_t p;
        p = point_t'({$urandom, $urandom, $urandom, $urandom});
        if (near)
        begin
            p.pos_x = 16'($signed($urandom_range(800)) - 400);
            p.pos_y = 16'($signed($urandom_range(800)) - 400);
        end
        p.path_end = done;
        return p;
    endfunction

    function automatic point_t edge_point(bit hi, bit done);
        point_t p;
        p = hi ? '1 : '0;
        p.pos_x = hi ? 16'sh7fff : 16'sh8000;
        p.pos_y = hi ? 16'sh7fff : 16'sh8000;
        p.path_end = done;
        return p;
    endfunction

    task automatic random_paths(int n);
        int k;
        int len;
        bit near;
        while (n > 0)
        begin
            len = $urandom_range(9, 1);
            near = $urandom_range(1);
            if ($urandom_range(9) == 0)
                len = 1;
            for (k = 0; k < len; k++)
                send_point(rand_point(k == len - 1 && $urandom_range(4) != 0, near));
            n -= len;
        end
    endtask

    initial
    begin
        logic [11:0] steps[5];
        steps = '{12'd1, 12'd4095, 12'd0, 12'd200, 12'd16};
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        send_point(edge_point(0, 1));
        send_point(edge_point(1, 1));
        send_point(edge_point(0, 0));
        send_point(edge_point(1, 0));
        send_point(edge_point(0, 0));
        send_point(edge_point(1, 0));
        send_point(rand_point(0, 1));
        send_point(rand_point(1, 1));
        send_point(rand_point(0, 0));
        send_point(rand_point(0, 0));
        send_point(rand_point(1, 0));
        send_point(rand_point(0, 0));
        send_point(rand_point(0, 0));
        send_point(rand_point(1, 0));
        drain();

        foreach (steps[i])
        begin
            write_step(steps[i]);
            send_point(rand_point(0, 0));
            send_point(rand_point(0, 1));
            send_point(rand_point(0, 1));
            send_point(rand_point(1, 1));
            drain();
        end
        write_step(STEP_RESET);

        send_idle_pct = 38;
        recv_idle_pct = 87;
        random_paths(110);
        drain();
        write_step(12'($urandom_range(4095)));
        send_idle_pct = 87;
        recv_idle_pct = 38;
        random_paths(110);
        drain();
        write_step(12'd0);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        fork
            begin
                hold_off = 1;
                repeat (400) @(posedge clk);
                hold_off = 0;
            end
            random_paths(40);
        join
        drain();
        write_step(STEP_RESET);
        random_paths(70);
        drain();

        $display("%0d control points sent, %0d tessellated points checked", sent, sb.checked);
        $display("covered step extremes, short and single point paths, long stalls");
        if (sb.errors == 0 && sb.due_points.size() == 0)
            $display("** cubic_bezier_tessellator: PASSED **");
        else
            $display("** cubic_bezier_tessellator: FAILED **");
        $finish;
    end
endmodule
